### src/mfw_pkg.sv
// Package for the windowed median filter: field widths, register indexes,
// and the request, result and window tag types.
// No dependencies.
`default_nettype none

package mfw_pkg;

    localparam int PIX_BITS           = 8;
    localparam int ROW_BITS           = 12;
    localparam int COL_BITS           = 10;
    localparam int IMG_W_BITS         = 11;
    localparam int IMG_H_BITS         = 13;
    localparam int CFG_DATA_BITS      = 13;
    localparam int CFG_INDEX_BITS     = 1;
    localparam int MAX_HEIGHT         = 4096;
    localparam int RESET_IMAGE_WIDTH  = 256;
    localparam int RESET_IMAGE_HEIGHT = 256;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic [PIX_BITS-1:0] pixel_in;
        logic                frame_start;
    } mfw_pixel_t;

    typedef struct packed {
        logic [PIX_BITS-1:0] median_out;
        logic [ROW_BITS-1:0] out_row;
        logic [COL_BITS-1:0] out_col;
        logic                last_of_run;
        logic                frame_done;
    } mfw_result_t;

    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                last_of_run;
        logic                frame_done;
    } mfw_tag_t;

endpackage

`default_nettype wire

### src/median_filter_window.sv
// Streaming WINDOW x WINDOW median filter with mirrored borders.
// Holds the line store, counters, column history and result sequencer.
// Depends on mfw_pkg and mfw_median.
//
//  Channel  Dir  Handshake                   Payload
//  pixel    in   pixel_valid / pixel_stall   mfw_pixel_t
//  result   out  result_valid / result_stall mfw_result_t
//  cfg      in   cfg_we                      cfg_index, cfg_data
//
// One request per clock while each request yields at most one result and
// result_stall is low. A request in the last column or on the last row yields
// up to (WINDOW/2+1)^2 results; the sequencer issues one window per cycle
// while result_stall is low, and the pixel side stalls until such a request's
// results are all issued. The first result of a request passes the write-back
// stage, the sequencer and the median unit's window, rank and output registers.
// Reset clears counters and control only; the line store is not cleared.
// result_stall freezes the median pipeline while a result is offered; pixel_stall rises while the
// sequencer still owes results for the previous request.
`default_nettype none

module median_filter_window
    import mfw_pkg::*;
#(
    parameter int WINDOW    = 3,
    parameter int MAX_WIDTH = 1024
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       pixel_valid,
    output logic                            pixel_stall,
    input  wire mfw_pixel_t                 pixel,
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output mfw_result_t                     result,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int HALF       = WINDOW / 2;
    localparam int AREA       = WINDOW * WINDOW;
    localparam int SLOT_BITS  = $clog2(WINDOW);
    localparam int ADDR_BITS  = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS = $clog2(MAX_WIDTH + 1);
    localparam int CSUM_BITS  = ADDR_BITS + 1;
    localparam int LINE_BITS  = WINDOW * PIX_BITS;
    localparam int COL_SBITS  = CSUM_BITS + 2;
    localparam int ROW_SBITS  = IMG_H_BITS + 2;
    localparam int RESET_W    = (RESET_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                                : RESET_IMAGE_WIDTH;

    localparam logic [WIDTH_BITS-1:0] MIN_W      = WIDTH_BITS'(HALF + 1);
    localparam logic [WIDTH_BITS-1:0] MAX_W      = WIDTH_BITS'(MAX_WIDTH);
    localparam logic [IMG_H_BITS-1:0] MIN_H      = IMG_H_BITS'(HALF + 1);
    localparam logic [IMG_H_BITS-1:0] MAX_H      = IMG_H_BITS'(MAX_HEIGHT);
    localparam logic [ROW_BITS-1:0]   HALF_ROW   = ROW_BITS'(HALF);
    localparam logic [ADDR_BITS-1:0]  HALF_COL   = ADDR_BITS'(HALF);
    localparam logic [SLOT_BITS-1:0]  LAST_SLOT  = SLOT_BITS'(WINDOW - 1);

    // configuration
    logic [WIDTH_BITS-1:0]  width_reg;
    logic [WIDTH_BITS-1:0]  width_next;
    logic [IMG_H_BITS-1:0]  height_reg;
    logic [IMG_H_BITS-1:0]  height_next;
    logic [CSUM_BITS-1:0]   width_ext;

    // position counters
    logic [ROW_BITS-1:0]    row_count_reg;
    logic [ROW_BITS-1:0]    row_count_next;
    logic [ADDR_BITS-1:0]   col_count_reg;
    logic [ADDR_BITS-1:0]   col_count_next;
    logic [SLOT_BITS-1:0]   slot_count_reg;
    logic [SLOT_BITS-1:0]   slot_count_next;
    logic [ROW_BITS-1:0]    in_row;
    logic [ADDR_BITS-1:0]   in_col;
    logic [SLOT_BITS-1:0]   in_slot;

    // line store and write-back stage
    logic [LINE_BITS-1:0]   line_store [MAX_WIDTH];
    logic [LINE_BITS-1:0]   rd_word_reg;
    logic [LINE_BITS-1:0]   fwd_word_reg;
    logic                   fwd_hit_reg;
    logic                   s1_valid_reg;
    logic [PIX_BITS-1:0]    s1_pix_reg;
    logic [ROW_BITS-1:0]    s1_row_reg;
    logic [ADDR_BITS-1:0]   s1_col_reg;
    logic [SLOT_BITS-1:0]   s1_slot_reg;
    logic [LINE_BITS-1:0]   merged;
    logic                   produce;
    logic                   last_row;
    logic                   last_col;
    logic                   accept;
    logic                   s1_fire;

    // column history and sequencer
    logic [LINE_BITS-1:0]   hist_reg [WINDOW];
    logic                   seq_busy_reg;
    logic                   seq_busy_next;
    logic [ROW_BITS-1:0]    seq_row_reg;
    logic [ROW_BITS-1:0]    seq_row_next;
    logic [ADDR_BITS-1:0]   seq_col_reg;
    logic [ADDR_BITS-1:0]   seq_col_next;
    logic [ROW_BITS-1:0]    seq_row_hi_reg;
    logic [ROW_BITS-1:0]    seq_row_hi_next;
    logic [ADDR_BITS-1:0]   seq_col_lo_reg;
    logic [ADDR_BITS-1:0]   seq_col_lo_next;
    logic [ADDR_BITS-1:0]   seq_col_hi_reg;
    logic [ADDR_BITS-1:0]   seq_col_hi_next;
    logic [ROW_BITS-1:0]    item_row_reg;
    logic [ROW_BITS-1:0]    item_row_next;
    logic [ADDR_BITS-1:0]   item_col_reg;
    logic [ADDR_BITS-1:0]   item_col_next;
    logic [SLOT_BITS-1:0]   item_slot_reg;
    logic [SLOT_BITS-1:0]   item_slot_next;
    logic                   seq_last;
    logic                   seq_issue;
    logic                   seq_free;
    logic                   take;

    logic [AREA-1:0][PIX_BITS-1:0] window;
    mfw_tag_t                      tag;

    assign width_ext = CSUM_BITS'(width_reg);

    // configuration writes, clamped to the supported range
    always_comb
    begin
        logic [IMG_W_BITS-1:0] w_raw;
        logic [IMG_H_BITS-1:0] h_raw;
        w_raw       = cfg_data[IMG_W_BITS-1:0];
        h_raw       = cfg_data[IMG_H_BITS-1:0];
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:
                begin
                    if (IMG_H_BITS'(w_raw) < IMG_H_BITS'(HALF + 1))
                        width_next = MIN_W;
                    else if (IMG_H_BITS'(w_raw) > IMG_H_BITS'(MAX_WIDTH))
                        width_next = MAX_W;
                    else
                        width_next = WIDTH_BITS'(w_raw);
                end
                CFG_IMAGE_HEIGHT:
                begin
                    if (h_raw < MIN_H)
                        height_next = MIN_H;
                    else if (h_raw > MAX_H)
                        height_next = MAX_H;
                    else
                        height_next = h_raw;
                end
                default:
                begin
                    width_next  = width_reg;
                    height_next = height_reg;
                end
            endcase
        end
    end

    // position of the incoming pixel and of the one after it
    always_comb
    begin
        logic [IMG_H_BITS-1:0] cur_row;
        logic [CSUM_BITS-1:0]  cur_col;
        logic [SLOT_BITS-1:0]  cur_slot;
        logic [IMG_H_BITS-1:0] nxt_row;
        logic [CSUM_BITS-1:0]  nxt_col;
        logic [SLOT_BITS-1:0]  nxt_slot;
        cur_row  = IMG_H_BITS'(row_count_reg);
        cur_col  = CSUM_BITS'(col_count_reg);
        cur_slot = slot_count_reg;
        if (pixel.frame_start)
        begin
            cur_row  = '0;
            cur_col  = '0;
            cur_slot = '0;
        end
        if (cur_col >= width_ext)
        begin
            cur_col  = '0;
            cur_row  = cur_row + IMG_H_BITS'(1);
            cur_slot = (cur_slot == LAST_SLOT) ? '0 : cur_slot + SLOT_BITS'(1);
        end
        if (cur_row >= height_reg)
        begin
            cur_row  = '0;
            cur_slot = '0;
        end
        in_row  = ROW_BITS'(cur_row);
        in_col  = ADDR_BITS'(cur_col);
        in_slot = cur_slot;

        nxt_row  = cur_row;
        nxt_col  = cur_col + CSUM_BITS'(1);
        nxt_slot = cur_slot;
        if (nxt_col >= width_ext)
        begin
            nxt_col  = '0;
            nxt_row  = nxt_row + IMG_H_BITS'(1);
            nxt_slot = (nxt_slot == LAST_SLOT) ? '0 : nxt_slot + SLOT_BITS'(1);
            if (nxt_row >= height_reg)
            begin
                nxt_row  = '0;
                nxt_slot = '0;
            end
        end
        row_count_next  = ROW_BITS'(nxt_row);
        col_count_next  = ADDR_BITS'(nxt_col);
        slot_count_next = nxt_slot;
    end

    assign seq_last    = (seq_row_reg == seq_row_hi_reg) && (seq_col_reg == seq_col_hi_reg);
    assign seq_issue   = seq_busy_reg && take;
    assign seq_free    = !seq_busy_reg || (seq_issue && seq_last);
    assign s1_fire     = s1_valid_reg && seq_free;
    assign pixel_stall = s1_valid_reg && !seq_free;
    assign accept      = pixel_valid && !pixel_stall;

    // merge the pixel into its column word
    always_comb
    begin
        merged = fwd_hit_reg ? fwd_word_reg : rd_word_reg;
        merged[s1_slot_reg*PIX_BITS +: PIX_BITS] = s1_pix_reg;
        produce  = (s1_row_reg >= HALF_ROW) && (s1_col_reg >= HALF_COL);
        last_row = (IMG_H_BITS'(s1_row_reg) == height_reg - IMG_H_BITS'(1));
        last_col = (CSUM_BITS'(s1_col_reg) == width_ext - CSUM_BITS'(1));
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            line_store[s1_col_reg] <= merged;
        end
        if (accept)
        begin
            rd_word_reg <= line_store[in_col];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_word_reg <= merged;
            s1_pix_reg   <= pixel.pixel_in;
            s1_row_reg   <= in_row;
            s1_col_reg   <= in_col;
            s1_slot_reg  <= in_slot;
        end
        if (s1_fire)
        begin
            hist_reg[0] <= merged;
            for (int k = 1; k < WINDOW; k++)
            begin
                hist_reg[k] <= hist_reg[k-1];
            end
        end
    end

    // sequencer: walk the owed results row by row, columns within each row
    always_comb
    begin
        seq_busy_next   = seq_busy_reg;
        seq_row_next    = seq_row_reg;
        seq_col_next    = seq_col_reg;
        seq_row_hi_next = seq_row_hi_reg;
        seq_col_lo_next = seq_col_lo_reg;
        seq_col_hi_next = seq_col_hi_reg;
        item_row_next   = item_row_reg;
        item_col_next   = item_col_reg;
        item_slot_next  = item_slot_reg;
        if (seq_issue)
        begin
            if (seq_last)
            begin
                seq_busy_next = 1'b0;
            end
            else if (seq_col_reg == seq_col_hi_reg)
            begin
                seq_row_next = seq_row_reg + ROW_BITS'(1);
                seq_col_next = seq_col_lo_reg;
            end
            else
            begin
                seq_col_next = seq_col_reg + ADDR_BITS'(1);
            end
        end
        if (s1_fire && produce)
        begin
            seq_busy_next   = 1'b1;
            seq_row_next    = s1_row_reg - HALF_ROW;
            seq_col_next    = s1_col_reg - HALF_COL;
            seq_col_lo_next = s1_col_reg - HALF_COL;
            seq_col_hi_next = last_col ? s1_col_reg : s1_col_reg - HALF_COL;
            seq_row_hi_next = last_row ? s1_row_reg : s1_row_reg - HALF_ROW;
            item_row_next   = s1_row_reg;
            item_col_next   = s1_col_reg;
            item_slot_next  = s1_slot_reg;
        end
    end

    // gather the mirrored window from the column history
    always_comb
    begin
        logic signed [COL_SBITS-1:0] ci;
        logic signed [COL_SBITS-1:0] wl;
        logic signed [COL_SBITS-1:0] mc;
        logic signed [COL_SBITS-1:0] kd;
        logic signed [ROW_SBITS-1:0] ri;
        logic signed [ROW_SBITS-1:0] hl;
        logic signed [ROW_SBITS-1:0] mr;
        logic signed [ROW_SBITS-1:0] rd;
        logic [SLOT_BITS:0]          sd;
        logic [SLOT_BITS-1:0]        col_idx [WINDOW];
        logic [SLOT_BITS-1:0]        row_slot [WINDOW];
        wl = COL_SBITS'(width_reg) - COL_SBITS'(1);
        hl = ROW_SBITS'(height_reg) - ROW_SBITS'(1);
        for (int a = 0; a < WINDOW; a++)
        begin
            ci = COL_SBITS'(seq_col_reg) + COL_SBITS'(a) - COL_SBITS'(HALF);
            if (ci < 0)
                mc = -ci;
            else if (ci > wl)
                mc = (wl <<< 1) - ci;
            else
                mc = ci;
            kd = COL_SBITS'(item_col_reg) - mc;
            col_idx[a] = kd[SLOT_BITS-1:0];

            ri = ROW_SBITS'(seq_row_reg) + ROW_SBITS'(a) - ROW_SBITS'(HALF);
            if (ri < 0)
                mr = -ri;
            else if (ri > hl)
                mr = (hl <<< 1) - ri;
            else
                mr = ri;
            rd = ROW_SBITS'(item_row_reg) - mr;
            sd = {1'b0, item_slot_reg} - {1'b0, rd[SLOT_BITS-1:0]};
            if (sd[SLOT_BITS])
            begin
                sd = sd + (SLOT_BITS+1)'(WINDOW);
            end
            row_slot[a] = sd[SLOT_BITS-1:0];
        end
        for (int ra = 0; ra < WINDOW; ra++)
        begin
            for (int ca = 0; ca < WINDOW; ca++)
            begin
                window[ra*WINDOW + ca] =
                    hist_reg[col_idx[ca]][row_slot[ra]*PIX_BITS +: PIX_BITS];
            end
        end
        tag.row         = seq_row_reg;
        tag.col         = COL_BITS'(seq_col_reg);
        tag.last_of_run = seq_last;
        tag.frame_done  = (IMG_H_BITS'(seq_row_reg) == height_reg - IMG_H_BITS'(1)) &&
                          (CSUM_BITS'(seq_col_reg) == width_ext - CSUM_BITS'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= WIDTH_BITS'(RESET_W);
            height_reg     <= IMG_H_BITS'(RESET_IMAGE_HEIGHT);
            row_count_reg  <= '0;
            col_count_reg  <= '0;
            slot_count_reg <= '0;
            s1_valid_reg   <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            seq_busy_reg   <= 1'b0;
            seq_row_reg    <= '0;
            seq_col_reg    <= '0;
            seq_row_hi_reg <= '0;
            seq_col_lo_reg <= '0;
            seq_col_hi_reg <= '0;
            item_row_reg   <= '0;
            item_col_reg   <= '0;
            item_slot_reg  <= '0;
        end
        else
        begin
            width_reg      <= width_next;
            height_reg     <= height_next;
            seq_busy_reg   <= seq_busy_next;
            seq_row_reg    <= seq_row_next;
            seq_col_reg    <= seq_col_next;
            seq_row_hi_reg <= seq_row_hi_next;
            seq_col_lo_reg <= seq_col_lo_next;
            seq_col_hi_reg <= seq_col_hi_next;
            item_row_reg   <= item_row_next;
            item_col_reg   <= item_col_next;
            item_slot_reg  <= item_slot_next;
            if (accept)
            begin
                row_count_reg  <= row_count_next;
                col_count_reg  <= col_count_next;
                slot_count_reg <= slot_count_next;
                // forward the word written this cycle to the same column
                fwd_hit_reg    <= s1_fire && (in_col == s1_col_reg);
            end
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;
        end
    end

    mfw_median #(
        .WINDOW (WINDOW)
    ) u_median (
        .clk          (clk),
        .rst_n        (rst_n),
        .issue        (seq_issue),
        .take         (take),
        .window       (window),
        .tag          (tag),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

### src/mfw_median.sv
// Median unit: registers one window per cycle while take is high, ranks every
// element against the others, then selects the middle rank into the output register.
// Depends on mfw_pkg.
`default_nettype none

module mfw_median
    import mfw_pkg::*;
#(
    parameter int WINDOW = 3
)
(
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       issue,
    output logic                                            take,
    input  wire logic [WINDOW*WINDOW-1:0][PIX_BITS-1:0]     window,
    input  wire mfw_tag_t                                   tag,
    output logic                                            result_valid,
    input  wire logic                                       result_stall,
    output mfw_result_t                                     result
);

    localparam int AREA = WINDOW * WINDOW;
    localparam int RANK_BITS = $clog2(AREA);
    localparam logic [RANK_BITS-1:0] MID_RANK = RANK_BITS'(AREA / 2);

    logic                                 v1_reg;
    logic                                 v2_reg;
    logic                                 out_valid_reg;
    logic [AREA-1:0][PIX_BITS-1:0]        win1_reg;
    logic [AREA-1:0][PIX_BITS-1:0]        win2_reg;
    logic [AREA-1:0][RANK_BITS-1:0]       rank2_reg;
    logic [AREA-1:0][RANK_BITS-1:0]       rank_next;
    mfw_tag_t                             tag1_reg;
    mfw_tag_t                             tag2_reg;
    mfw_result_t                          out_reg;
    mfw_result_t                          out_next;
    logic [PIX_BITS-1:0]                  median_sel;

    assign take         = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // rank: count smaller elements, break ties by position
    always_comb
    begin
        logic [AREA-1:0] below;
        below = '0;
        for (int i = 0; i < AREA; i++)
        begin
            for (int j = 0; j < AREA; j++)
            begin
                below[j] = (win1_reg[j] < win1_reg[i]) ||
                           ((j < i) && (win1_reg[j] == win1_reg[i]));
            end
            rank_next[i] = RANK_BITS'($countones(below));
        end
    end

    always_comb
    begin
        median_sel = '0;
        for (int i = 0; i < AREA; i++)
        begin
            if (rank2_reg[i] == MID_RANK)
            begin
                median_sel = median_sel | win2_reg[i];
            end
        end
        out_next.median_out  = median_sel;
        out_next.out_row     = tag2_reg.row;
        out_next.out_col     = tag2_reg.col;
        out_next.last_of_run = tag2_reg.last_of_run;
        out_next.frame_done  = tag2_reg.frame_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            v1_reg        <= issue;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            win1_reg  <= window;
            tag1_reg  <= tag;
            win2_reg  <= win1_reg;
            rank2_reg <= rank_next;
            tag2_reg  <= tag1_reg;
            out_reg   <= out_next;
        end
    end

endmodule

`default_nettype wire

### src/mfw_checker.sv
// Port checker for the median filter's result channel, attached by bind.
// Depends on mfw_pkg and median_filter_window.
`default_nettype none

module mfw_checker
    import mfw_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        result_valid,
    input wire logic        result_stall,
    input wire mfw_result_t result
);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result_valid dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result changed while stalled");

    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.frame_done |-> result.last_of_run)
        else $error("frame_done on a result that does not end its run");

    a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && !result.last_of_run)
        ##1 (result_valid && !result_stall)
        |-> (result.out_row == $past(result.out_row) &&
             result.out_col == $past(result.out_col) + COL_BITS'(1)) ||
            (result.out_row == $past(result.out_row) + ROW_BITS'(1)))
        else $error("results of one run out of order");

endmodule

bind median_filter_window mfw_checker u_mfw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire
